@@ hdl/spq_pkg.sv @@
// Shared types and codes for the sorted priority queue.
// No dependencies; used by spq_cell and sorted_priority_queue.
package spq_pkg;

  typedef enum logic [1:0] {
    FUNC_INSERT  = 2'd0,
    FUNC_EXTRACT = 2'd1,
    FUNC_CHANGE  = 2'd2
  } spq_func_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } spq_status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE
  } spq_cell_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_REINSERT
  } spq_state_e;

  localparam int unsigned KeyW  = 16;
  localparam int unsigned PrioW = 32;

  typedef struct packed {
    logic                    valid;
    logic [KeyW-1:0]         key;
    logic signed [PrioW-1:0] prio;
  } spq_entry_t;

endpackage

@@ hdl/spq_cell.sv @@
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
// Depends on spq_pkg.
module spq_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  spq_pkg::spq_cell_op_e             op_i,
  input  logic [spq_pkg::KeyW-1:0]          key_i,
  input  logic signed [spq_pkg::PrioW-1:0]  prio_i,
  input  spq_pkg::spq_entry_t               left_i,
  input  logic                              left_keep_i,
  input  spq_pkg::spq_entry_t               right_i,
  input  logic                              seen_i,
  output spq_pkg::spq_entry_t               entry_o,
  output logic                              keep_o,
  output logic                              seen_o
);

  logic                             valid_q, valid_d;
  logic [spq_pkg::KeyW-1:0]         key_q, key_d;
  logic signed [spq_pkg::PrioW-1:0] prio_q, prio_d;
  logic                             del;

  // keep: this entry stays ahead of a new request with priority prio_i
  assign keep_o = valid_q && (prio_q < prio_i);
  // delete from the first match onward, or everything when seen_i comes in high
  assign del    = seen_i || (valid_q && (key_q == key_i));
  assign seen_o = del;

  assign entry_o.valid = valid_q;
  assign entry_o.key   = key_q;
  assign entry_o.prio  = prio_q;

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    prio_d  = prio_q;
    unique case (op_i)
      spq_pkg::CELL_INSERT: begin
        if (!keep_o) begin
          if (left_keep_i) begin
            valid_d = 1'b1;
            key_d   = key_i;
            prio_d  = prio_i;
          end else begin
            valid_d = left_i.valid;
            key_d   = left_i.key;
            prio_d  = left_i.prio;
          end
        end
      end
      spq_pkg::CELL_DELETE: begin
        if (del) begin
          valid_d = right_i.valid;
          key_d   = right_i.key;
          prio_d  = right_i.prio;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    prio_q <= prio_d;
  end

endmodule

@@ hdl/sorted_priority_queue.sv @@
// Sorted priority queue: a row of DEPTH spq_cell slots plus the command sequencer.
// Depends on spq_pkg and spq_cell.
//
// Priority queue kept sorted by ascending signed priority in a row of cells; the
// head is always cell 0. A request is taken when start_i is high and busy_o is low.
// Insert and extract finish in the accepting cycle and their result strobes on
// done_o in the next cycle; busy_o stays low, so one of these may be issued
// every cycle. Change runs a delete pass through the row and, when the key is
// found, an insert pass in ST_REINSERT, during which busy_o is high; a missing
// key returns status 2 with no insert pass. Each pass goes through the whole
// row combinationally, so the time per request does not depend on DEPTH. Results
// cannot be held off: each appears for exactly one cycle with done_o high.
// head_key_o, is_empty_o and entry_count_out_o show the queue after the request.
module sorted_priority_queue #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [1:0]                        func_i,
  input  logic [spq_pkg::KeyW-1:0]          item_key_i,
  input  logic signed [spq_pkg::PrioW-1:0]  item_priority_i,
  output logic                              done_o,
  output logic [spq_pkg::KeyW-1:0]          out_key_o,
  output logic [1:0]                        status_o,
  output logic [spq_pkg::KeyW-1:0]          head_key_o,
  output logic                              is_empty_o,
  output logic [CntW-1:0]                   entry_count_out_o
);

  spq_pkg::spq_state_e              state_q, state_d;
  logic [CntW-1:0]                  cnt_q, cnt_d;
  logic                             done_q, done_d;
  logic [spq_pkg::KeyW-1:0]         out_key_q, out_key_d;
  spq_pkg::spq_status_e             status_q, status_d;
  logic [spq_pkg::KeyW-1:0]         pend_key_q;
  logic signed [spq_pkg::PrioW-1:0] pend_prio_q;

  spq_pkg::spq_cell_op_e            cell_op;
  logic [spq_pkg::KeyW-1:0]         cell_key;
  logic signed [spq_pkg::PrioW-1:0] cell_prio;
  logic                             seen_head;

  spq_pkg::spq_entry_t              entry_w [DEPTH];
  logic                             keep_w  [DEPTH];
  logic                             seen_w  [DEPTH+1];

  spq_pkg::spq_func_e               func;
  logic                             accept;
  logic                             full;
  logic                             empty;
  logic                             found;

  assign func      = spq_pkg::spq_func_e'(func_i);
  assign busy_o    = (state_q == spq_pkg::ST_REINSERT);
  assign accept    = start_i && !busy_o;
  assign full      = (cnt_q == CntW'(DEPTH));
  assign empty     = (cnt_q == '0);
  assign found     = seen_w[DEPTH];
  assign seen_w[0] = seen_head;

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_pkg::spq_entry_t left_e, right_e;
    logic                left_keep;
    if (i == 0) begin : g_first
      assign left_e    = '0;
      assign left_keep = 1'b1;
    end else begin : g_mid
      assign left_e    = entry_w[i-1];
      assign left_keep = keep_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = entry_w[i+1];
    end
    spq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .op_i        (cell_op),
      .key_i       (cell_key),
      .prio_i      (cell_prio),
      .left_i      (left_e),
      .left_keep_i (left_keep),
      .right_i     (right_e),
      .seen_i      (seen_w[i]),
      .entry_o     (entry_w[i]),
      .keep_o      (keep_w[i]),
      .seen_o      (seen_w[i+1])
    );
  end

  // command issued to the row
  always_comb begin
    cell_op   = spq_pkg::CELL_HOLD;
    cell_key  = item_key_i;
    cell_prio = item_priority_i;
    seen_head = 1'b0;
    if (state_q == spq_pkg::ST_REINSERT) begin
      cell_op   = spq_pkg::CELL_INSERT;
      cell_key  = pend_key_q;
      cell_prio = pend_prio_q;
    end else if (accept) begin
      unique case (func)
        spq_pkg::FUNC_INSERT: begin
          if (!full) cell_op = spq_pkg::CELL_INSERT;
        end
        spq_pkg::FUNC_EXTRACT: begin
          if (!empty) begin
            cell_op   = spq_pkg::CELL_DELETE;
            seen_head = 1'b1;
          end
        end
        spq_pkg::FUNC_CHANGE: begin
          cell_op = spq_pkg::CELL_DELETE;
        end
        default: begin
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      spq_pkg::ST_IDLE: begin
        if (accept && func == spq_pkg::FUNC_CHANGE && found) state_d = spq_pkg::ST_REINSERT;
      end
      spq_pkg::ST_REINSERT: state_d = spq_pkg::ST_IDLE;
      default:              state_d = spq_pkg::ST_IDLE;
    endcase
  end

  // result and count
  always_comb begin
    cnt_d     = cnt_q;
    done_d    = 1'b0;
    out_key_d = '0;
    status_d  = spq_pkg::STAT_OK;
    unique case (state_q)
      spq_pkg::ST_IDLE: begin
        if (accept) begin
          done_d = 1'b1;
          unique case (func)
            spq_pkg::FUNC_INSERT: begin
              if (full) status_d = spq_pkg::STAT_FULL;
              else      cnt_d    = cnt_q + CntW'(1);
            end
            spq_pkg::FUNC_EXTRACT: begin
              if (empty) begin
                status_d = spq_pkg::STAT_EMPTY;
              end else begin
                out_key_d = entry_w[0].key;
                cnt_d     = cnt_q - CntW'(1);
              end
            end
            spq_pkg::FUNC_CHANGE: begin
              if (found) begin
                done_d = 1'b0;
                cnt_d  = cnt_q - CntW'(1);
              end else begin
                status_d = spq_pkg::STAT_NOT_FOUND;
              end
            end
            default: begin
            end
          endcase
        end
      end
      spq_pkg::ST_REINSERT: begin
        done_d = 1'b1;
        cnt_d  = cnt_q + CntW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spq_pkg::ST_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_key_q <= out_key_d;
    status_q  <= status_d;
    if (accept) begin
      pend_key_q  <= item_key_i;
      pend_prio_q <= item_priority_i;
    end
  end

  assign done_o            = done_q;
  assign out_key_o         = out_key_q;
  assign status_o          = status_q;
  assign head_key_o        = entry_w[0].valid ? entry_w[0].key : '0;
  assign is_empty_o        = empty;
  assign entry_count_out_o = cnt_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("entry count above depth");

  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_w[0].valid == (cnt_q != '0))
    else $error("head cell valid disagrees with count");

  a_tail_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_w[DEPTH-1].valid == (cnt_q == CntW'(DEPTH)))
    else $error("tail cell valid disagrees with count");

  a_reinsert_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == spq_pkg::ST_REINSERT) |=> (done_o && status_o == spq_pkg::STAT_OK))
    else $error("change request did not complete after reinsert");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == spq_pkg::STAT_FULL) |-> (cnt_q == CntW'(DEPTH)))
    else $error("full status with free slots");
`endif

endmodule
